>>> hdl/dpim_pkg.sv
// ----------------------------------------------------------------------------
// dpim_pkg
// shared widths, codes and reset values for the dual pulse interval meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpim_pkg;

	localparam int BEATS_DEF       = 10;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int KIND_BITS   = 2;
	localparam int COUNT_BITS  = 4;
	localparam int TICK_BITS   = 16;
	localparam int SUM_BITS    = 20;
	localparam int OUT_BITS    = 16;
	localparam int SUM_SHIFT   = 3;
	localparam int APB_DATA    = 32;
	localparam int APB_ADDR    = 4;
	localparam int REG_SEL_LSB = 2;

	localparam int HIGH_THR_RST = 900;
	localparam int LOW_THR_RST  = 20;
	localparam int TIMEOUT_RST  = 10000;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_TICK   = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_START  = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_HIGH_THR = 2'd0,
		REG_LOW_THR  = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_NONE     = 2'd3
	} reg_sel_t;

	// per channel commands from the top level
	typedef struct packed {
		logic clear;
		logic tick;
		logic sample_en;
	} chan_ctrl_t;

	// per channel next-state view used to build the result
	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [SUM_BITS-1:0]   sum;
	} chan_stat_t;

endpackage

>>> hdl/dpim_item_if.sv
// ----------------------------------------------------------------------------
// dpim_item_if
// input item channel: kind and one sample pair
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpim_item_if #(
	parameter int SAMPLE_BITS = dpim_pkg::SAMPLE_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [dpim_pkg::KIND_BITS-1:0] kind;
	logic [SAMPLE_BITS-1:0]         sample_a;
	logic [SAMPLE_BITS-1:0]         sample_b;

	modport source (output valid, kind, sample_a, sample_b, input ready);
	modport sink   (input valid, kind, sample_a, sample_b, output ready);
endinterface

>>> hdl/dpim_result_if.sv
// ----------------------------------------------------------------------------
// dpim_result_if
// result item channel: both intervals, timeout flag and beat counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpim_result_if;
	logic                            valid;
	logic                            ready;
	logic [dpim_pkg::OUT_BITS-1:0]   beat_interval;
	logic [dpim_pkg::OUT_BITS-1:0]   transit_interval;
	logic                            timed_out;
	logic [dpim_pkg::COUNT_BITS-1:0] beats_a;
	logic [dpim_pkg::COUNT_BITS-1:0] beats_b;

	modport source (output valid, beat_interval, transit_interval, timed_out,
		beats_a, beats_b, input ready);
	modport sink   (input valid, beat_interval, transit_interval, timed_out,
		beats_a, beats_b, output ready);
endinterface

>>> hdl/dpim_channel.sv
// ----------------------------------------------------------------------------
// dpim_channel
// hysteresis beat detector with tick counter and interval accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpim_channel #(
	parameter int BEATS       = dpim_pkg::BEATS_DEF,
	parameter int SAMPLE_BITS = dpim_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dpim_pkg::chan_ctrl_t   ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] high_thr,
	input  logic [SAMPLE_BITS-1:0] low_thr,
	output dpim_pkg::chan_stat_t   stat
);
	import dpim_pkg::*;

	typedef enum logic [1:0] {
		AWAIT_HIGH    = 2'd0,
		AWAIT_LOW     = 2'd1,
		AWAIT_CAPTURE = 2'd2
	} phase_t;

	localparam logic [TICK_BITS-1:0]  TICK_MAX  = '1;
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
	localparam logic [COUNT_BITS-1:0] BEATS_CNT = COUNT_BITS'(BEATS);

	phase_t                phase_q, phase_d;
	logic [TICK_BITS-1:0]  ticks_q, ticks_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [SUM_BITS-1:0]   sum_q, sum_d;
	logic [SUM_BITS:0]     sum_add;
	logic                  hi, lo;

	assign hi      = sample > high_thr;
	assign lo      = sample < low_thr;
	assign sum_add = {1'b0, sum_q} + (SUM_BITS+1)'(ticks_q);

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		count_d = count_q;
		sum_d   = sum_q;
		if (ctrl.clear) begin
			phase_d = AWAIT_HIGH;
			ticks_d = '0;
			count_d = '0;
			sum_d   = '0;
		end else if (ctrl.tick) begin
			if (ticks_q != TICK_MAX)
				ticks_d = ticks_q + 1'b1;
		end else if (ctrl.sample_en) begin
			unique case (phase_q)
				AWAIT_HIGH: begin
					if (hi)
						phase_d = AWAIT_LOW;
				end
				AWAIT_LOW: begin
					if (lo)
						phase_d = AWAIT_CAPTURE;
				end
				AWAIT_CAPTURE: begin
					// a full channel parks here and captures nothing more
					if (hi && count_q < BEATS_CNT) begin
						// first interval is only a starting mark
						if (count_q != '0)
							sum_d = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
						ticks_d = '0;
						count_d = count_q + 1'b1;
						phase_d = AWAIT_HIGH;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= AWAIT_HIGH;
			ticks_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	assign stat.count = count_d;
	assign stat.sum   = sum_d;

endmodule

>>> hdl/dual_pulse_interval_meter_top.sv
// ----------------------------------------------------------------------------
// dual_pulse_interval_meter_top
// two-channel pulse interval meter with hysteresis beat detection
// ----------------------------------------------------------------------------
// usage
//   samples: input items. kind tick advances both tick counters and the
//   timeout, kind sample carries one sample per channel, kind start clears
//   the measurement and arms the timeout. other kinds are ignored.
//   results: one item per measurement, when both channels hold BEATS beats
//   or when the timeout runs out (timed_out set).
//   apb port: high_threshold at 0x0, low_threshold at 0x4, timeout_ticks at
//   0x8; write only while the block is idle.
// timing
//   an item is taken into the input register; when it moves on, its effect
//   lands in the channel state and any result in the output register.
//   one item per cycle sustained while no result waits on results.ready:
//   the only path is a compare and a 20-bit add per channel between the
//   input register and the state registers.
// reset
//   arst_n clears the measurement, drops both valids and reloads the
//   thresholds and timeout with their defaults.
// back-pressure
//   while a result waits on results.ready the input register holds its item
//   and samples.ready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_pulse_interval_meter_top #(
	parameter int BEATS       = dpim_pkg::BEATS_DEF,
	parameter int SAMPLE_BITS = dpim_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dpim_item_if.sink                       samples,
	dpim_result_if.source                   results,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dpim_pkg::APB_ADDR-1:0]   paddr,
	input  logic [dpim_pkg::APB_DATA-1:0]   pwdata,
	output logic [dpim_pkg::APB_DATA-1:0]   prdata,
	output logic                            pready
);
	import dpim_pkg::*;

	// configuration registers
	logic [SAMPLE_BITS-1:0] high_thr_q;
	logic [SAMPLE_BITS-1:0] low_thr_q;
	logic [TICK_BITS-1:0]   timeout_q;
	logic                   cfg_wr;
	reg_sel_t               reg_sel;

	// input register
	logic                   item_v_s1;
	kind_t                  kind_s1;
	logic [SAMPLE_BITS-1:0] sample_a_s1;
	logic [SAMPLE_BITS-1:0] sample_b_s1;

	// measurement control
	logic                   active_q;
	logic [TICK_BITS-1:0]   remaining_q;
	logic [TICK_BITS-1:0]   remaining_dec;
	logic                   advance;
	logic                   proc;
	logic                   do_start, do_tick, do_sample;
	logic                   emit;
	logic                   emit_to;
	chan_ctrl_t             ctrl;
	chan_stat_t             stat_a, stat_b;

	// result register
	logic                   res_v_q;
	logic [OUT_BITS-1:0]    beat_q, transit_q;
	logic                   timed_out_q;
	logic [COUNT_BITS-1:0]  beats_a_q, beats_b_q;

	localparam logic [COUNT_BITS-1:0] BEATS_CNT = COUNT_BITS'(BEATS);

	// saturate sum >> 3 to the result width
	function automatic logic [OUT_BITS-1:0] shrink(input logic [SUM_BITS-1:0] s);
		logic [SUM_BITS-SUM_SHIFT-1:0] v;
		v = s[SUM_BITS-1:SUM_SHIFT];
		shrink = (v[SUM_BITS-SUM_SHIFT-1:OUT_BITS] != '0) ? '1 : v[OUT_BITS-1:0];
	endfunction

	// ---------------- apb register file ----------------
	assign pready  = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[REG_SEL_LSB+1:REG_SEL_LSB]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= SAMPLE_BITS'(HIGH_THR_RST);
			low_thr_q  <= SAMPLE_BITS'(LOW_THR_RST);
			timeout_q  <= TICK_BITS'(TIMEOUT_RST);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_HIGH_THR: high_thr_q <= pwdata[SAMPLE_BITS-1:0];
				REG_LOW_THR:  low_thr_q  <= pwdata[SAMPLE_BITS-1:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HIGH_THR: prdata = APB_DATA'(high_thr_q);
			REG_LOW_THR:  prdata = APB_DATA'(low_thr_q);
			REG_TIMEOUT:  prdata = APB_DATA'(timeout_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// the held item moves on whenever the result slot is free or draining
	assign advance       = !res_v_q || results.ready;
	assign proc          = item_v_s1 && advance;
	assign samples.ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (samples.ready) begin
			item_v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			kind_s1     <= kind_t'(samples.kind);
			sample_a_s1 <= samples.sample_a;
			sample_b_s1 <= samples.sample_b;
		end
	end

	// ---------------- item decode ----------------
	// ticks and samples outside a measurement are dropped
	assign do_start  = proc && kind_s1 == KIND_START;
	assign do_tick   = proc && active_q && kind_s1 == KIND_TICK;
	assign do_sample = proc && active_q && kind_s1 == KIND_SAMPLE;

	assign ctrl.clear     = do_start;
	assign ctrl.tick      = do_tick;
	assign ctrl.sample_en = do_sample;

	assign remaining_dec = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;

	always_comb begin
		emit    = 1'b0;
		emit_to = 1'b0;
		if (do_start) begin
			// zero timeout ends the measurement straight away
			emit    = timeout_q == '0;
			emit_to = 1'b1;
		end else if (do_tick) begin
			emit    = remaining_dec == '0;
			emit_to = 1'b1;
		end else if (do_sample) begin
			emit    = stat_a.count >= BEATS_CNT && stat_b.count >= BEATS_CNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			remaining_q <= '0;
		end else begin
			if (do_start) begin
				remaining_q <= timeout_q;
				active_q    <= timeout_q != '0;
			end else if (do_tick) begin
				remaining_q <= remaining_dec;
				if (emit)
					active_q <= 1'b0;
			end else if (do_sample && emit) begin
				active_q <= 1'b0;
			end
		end
	end

	// ---------------- channels ----------------
	dpim_channel #(
		.BEATS       (BEATS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_chan_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (sample_a_s1),
		.high_thr (high_thr_q),
		.low_thr  (low_thr_q),
		.stat     (stat_a)
	);

	dpim_channel #(
		.BEATS       (BEATS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_chan_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (sample_b_s1),
		.high_thr (high_thr_q),
		.low_thr  (low_thr_q),
		.stat     (stat_b)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (results.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			beat_q      <= shrink(stat_a.sum);
			transit_q   <= shrink(stat_b.sum);
			timed_out_q <= emit_to;
			beats_a_q   <= stat_a.count;
			beats_b_q   <= stat_b.count;
		end
	end

	assign results.valid            = res_v_q;
	assign results.beat_interval    = beat_q;
	assign results.transit_interval = transit_q;
	assign results.timed_out        = timed_out_q;
	assign results.beats_a          = beats_a_q;
	assign results.beats_b          = beats_b_q;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dual pulse interval meter: a cycle-free
// predictor follows every accepted item and a result monitor compares each
// result item field by field; registers are set and read back over apb
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import dpim_pkg::*;

	localparam int BEATS            = BEATS_DEF;
	localparam int SAMPLE_W         = SAMPLE_BITS_DEF;
	localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
	localparam int SETTLE_CYCLES    = 6;
	localparam int RANDOM_ITEMS     = 500;
	localparam int RANDOM_RESULTS   = 40;
	localparam int RANDOM_ITEM_CAP  = 4000;
	localparam logic [SUM_BITS-1:0] SUM_LIMIT = '1;

	// detector state of one channel
	typedef enum logic [1:0] {
		PH_WAIT_HIGH    = 2'd0,
		PH_WAIT_LOW     = 2'd1,
		PH_WAIT_CAPTURE = 2'd2
	} beat_phase_t;

	typedef struct {
		beat_phase_t           phase;
		logic [TICK_BITS-1:0]  ticks;
		logic [COUNT_BITS-1:0] count;
		logic [SUM_BITS-1:0]   sum;
	} chan_t;

	typedef struct {
		logic [OUT_BITS-1:0]   beat;
		logic [OUT_BITS-1:0]   transit;
		logic                  timed_out;
		logic [COUNT_BITS-1:0] beats_a;
		logic [COUNT_BITS-1:0] beats_b;
	} meas_result_t;

	// how the result side holds off
	typedef enum logic [1:0] {
		SINK_ALWAYS  = 2'd0,
		SINK_RANDOM  = 2'd1,
		SINK_PATTERN = 2'd2
	} sink_mode_t;

	// flavours of the random measurement phases
	typedef enum logic [2:0] {
		MIX_NOMINAL      = 3'd0,
		MIX_NO_EDGES     = 3'd1,
		MIX_ALWAYS_EDGES = 3'd2,
		MIX_RANDOM       = 3'd3,
		MIX_INVERTED     = 3'd4,
		MIX_LONG         = 3'd5
	} mix_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// item channels and the apb port, all driven to known values from time zero
	dpim_item_if #(.SAMPLE_BITS(SAMPLE_W)) samples_if ();
	dpim_result_if                         results_if ();

	logic                 item_valid   = 1'b0;
	kind_t                item_kind    = KIND_TICK;
	logic [SAMPLE_W-1:0]  item_a       = '0;
	logic [SAMPLE_W-1:0]  item_b       = '0;
	logic                 sink_ready   = 1'b1;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [APB_ADDR-1:0]  paddr        = '0;
	logic [APB_DATA-1:0]  pwdata       = '0;
	logic [APB_DATA-1:0]  prdata;
	logic                 pready;

	assign samples_if.valid    = item_valid;
	assign samples_if.kind     = item_kind;
	assign samples_if.sample_a = item_a;
	assign samples_if.sample_b = item_b;
	assign results_if.ready    = sink_ready;

	dual_pulse_interval_meter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------------
	// predictor: register copies, measurement state and the expected results
	// ------------------------------------------------------------------------
	logic [SAMPLE_W-1:0]  high_thr    = SAMPLE_W'(HIGH_THR_RST);
	logic [SAMPLE_W-1:0]  low_thr     = SAMPLE_W'(LOW_THR_RST);
	logic [TICK_BITS-1:0] timeout_cfg = TICK_BITS'(TIMEOUT_RST);

	logic                 meas_active = 1'b0;
	logic [TICK_BITS-1:0] ticks_left  = '0;
	chan_t                chan_a;
	chan_t                chan_b;

	meas_result_t pending_results[$];

	int effective_items   = 0;
	int results_predicted = 0;
	int result_errors     = 0;
	int reg_errors        = 0;

	// sender and receiver behaviour, changed between phases
	bit         gaps_on    = 1'b0;
	int         gap_max    = 1;
	int         burst_left = 0;
	sink_mode_t sink_mode  = SINK_ALWAYS;
	int         stall_count = 0;

	function automatic void clear_measurement();
		meas_active   = 1'b0;
		ticks_left    = '0;
		chan_a.phase  = PH_WAIT_HIGH;
		chan_a.ticks  = '0;
		chan_a.count  = '0;
		chan_a.sum    = '0;
		chan_b        = chan_a;
	endfunction

	function automatic logic [OUT_BITS-1:0] scaled_interval(logic [SUM_BITS-1:0] sum);
		logic [SUM_BITS-SUM_SHIFT-1:0] shifted;
		shifted = sum[SUM_BITS-1:SUM_SHIFT];
		if (shifted > {OUT_BITS{1'b1}})
			return '1;
		return shifted[OUT_BITS-1:0];
	endfunction

	// end of a measurement: one result item, then idle until the next start
	function automatic void close_measurement(logic by_timeout);
		meas_result_t r;
		r.beat      = scaled_interval(chan_a.sum);
		r.transit   = scaled_interval(chan_b.sum);
		r.timed_out = by_timeout;
		r.beats_a   = chan_a.count;
		r.beats_b   = chan_b.count;
		pending_results.push_back(r);
		meas_active = 1'b0;
		results_predicted++;
	endfunction

	// high-low-high hysteresis; the first captured interval is dropped
	function automatic void capture_beat(logic [SAMPLE_W-1:0] s, inout chan_t ch);
		logic             hi;
		logic             lo;
		logic [SUM_BITS:0] total;
		hi = s > high_thr;
		lo = s < low_thr;
		if (hi && ch.phase == PH_WAIT_HIGH) begin
			ch.phase = PH_WAIT_LOW;
		end else if (lo && ch.phase == PH_WAIT_LOW) begin
			ch.phase = PH_WAIT_CAPTURE;
		end else if (hi && ch.phase == PH_WAIT_CAPTURE && ch.count < BEATS) begin
			if (ch.count >= 1) begin
				total  = ch.sum + ch.ticks;
				ch.sum = (total > SUM_LIMIT) ? SUM_LIMIT : total[SUM_BITS-1:0];
			end
			ch.ticks = '0;
			ch.count = ch.count + 1'b1;
			ch.phase = PH_WAIT_HIGH;
		end
	endfunction

	// one accepted item; returns whether the item had any effect
	function automatic bit meter_step(kind_t k, logic [SAMPLE_W-1:0] a,
		logic [SAMPLE_W-1:0] b);
		case (k)
			KIND_START: begin
				clear_measurement();
				meas_active = 1'b1;
				ticks_left  = timeout_cfg;
				if (ticks_left == 0)
					close_measurement(1'b1);
				return 1'b1;
			end
			KIND_TICK: begin
				if (!meas_active)
					return 1'b0;
				if (chan_a.ticks != '1)
					chan_a.ticks = chan_a.ticks + 1'b1;
				if (chan_b.ticks != '1)
					chan_b.ticks = chan_b.ticks + 1'b1;
				if (ticks_left != 0)
					ticks_left = ticks_left - 1'b1;
				if (ticks_left == 0)
					close_measurement(1'b1);
				return 1'b1;
			end
			KIND_SAMPLE: begin
				if (!meas_active)
					return 1'b0;
				capture_beat(a, chan_a);
				capture_beat(b, chan_b);
				if (chan_a.count >= BEATS && chan_b.count >= BEATS)
					close_measurement(1'b0);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// result monitor: each accepted result against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		meas_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: beat %0d transit %0d",
					results_if.beat_interval, results_if.transit_interval);
				result_errors++;
			end else begin
				want = pending_results.pop_front();
				if (results_if.beat_interval !== want.beat) begin
					$error("beat_interval: expected %0d, got %0d",
						want.beat, results_if.beat_interval);
					result_errors++;
				end
				if (results_if.transit_interval !== want.transit) begin
					$error("transit_interval: expected %0d, got %0d",
						want.transit, results_if.transit_interval);
					result_errors++;
				end
				if (results_if.timed_out !== want.timed_out) begin
					$error("timed_out: expected %0d, got %0d",
						want.timed_out, results_if.timed_out);
					result_errors++;
				end
				if (results_if.beats_a !== want.beats_a) begin
					$error("beats_a: expected %0d, got %0d",
						want.beats_a, results_if.beats_a);
					result_errors++;
				end
				if (results_if.beats_b !== want.beats_b) begin
					$error("beats_b: expected %0d, got %0d",
						want.beats_b, results_if.beats_b);
					result_errors++;
				end
			end
		end
	end

	// receiver hold-off: always ready, random, or a repeating stall pattern from stall_count
	always @(negedge clk) begin
		stall_count <= (stall_count == 10) ? 0 : stall_count + 1;
		case (sink_mode)
			SINK_RANDOM:  sink_ready <= ($urandom_range(3, 0) != 0);
			SINK_PATTERN: sink_ready <= (stall_count >= 5);
			default:      sink_ready <= 1'b1;
		endcase
	end

	// ------------------------------------------------------------------------
	// drivers; every task is entered and left at a falling edge
	// ------------------------------------------------------------------------

	// one item; bursts of random length with random gaps between them
	task automatic send_item(kind_t k, logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
		int gap;
		gap = 0;
		if (gaps_on) begin
			if (burst_left <= 0) begin
				gap        = $urandom_range(gap_max, 1);
				burst_left = $urandom_range(12, 1);
			end
			burst_left--;
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_kind  <= k;
		item_a     <= a;
		item_b     <= b;
		do @(posedge clk); while (!samples_if.ready);
		if (meter_step(k, a, b))
			effective_items++;
		@(negedge clk);
	endtask

	// sender quiet, every expected result in, and the input register drained
	task automatic settle_block();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb: setup cycle, access cycle, then psel low again
	task automatic apb_access(bit is_write, reg_sel_t sel, logic [APB_DATA-1:0] wdata,
		output logic [APB_DATA-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= APB_ADDR'(sel) << REG_SEL_LSB;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [APB_DATA-1:0] field_bits(reg_sel_t sel,
		logic [APB_DATA-1:0] word);
		if (sel == REG_TIMEOUT)
			return APB_DATA'(word[TICK_BITS-1:0]);
		return APB_DATA'(word[SAMPLE_W-1:0]);
	endfunction

	task automatic check_register(reg_sel_t sel, logic [APB_DATA-1:0] want);
		logic [APB_DATA-1:0] got;
		apb_access(1'b0, sel, '0, got);
		if (field_bits(sel, got) !== field_bits(sel, want)) begin
			$error("register %s: expected %0d, got %0d", sel.name(),
				field_bits(sel, want), field_bits(sel, got));
			reg_errors++;
		end
	endtask

	// write, mirror into the predictor, read back
	task automatic set_register(reg_sel_t sel, logic [APB_DATA-1:0] value);
		logic [APB_DATA-1:0] unused;
		apb_access(1'b1, sel, value, unused);
		case (sel)
			REG_HIGH_THR: high_thr    = value[SAMPLE_W-1:0];
			REG_LOW_THR:  low_thr     = value[SAMPLE_W-1:0];
			REG_TIMEOUT:  timeout_cfg = value[TICK_BITS-1:0];
			default: ;
		endcase
		check_register(sel, value);
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [SAMPLE_W-1:0] any_sample();
		return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
	endfunction

	// mostly the level that moves the detector on, sometimes anything
	function automatic logic [SAMPLE_W-1:0] shaped_sample(beat_phase_t ph);
		if ($urandom_range(4, 0) == 0)
			return any_sample();
		if (ph == PH_WAIT_LOW) begin
			if (low_thr != 0)
				return SAMPLE_W'($urandom_range(int'(low_thr) - 1, 0));
		end else if (high_thr != SAMPLE_MAX) begin
			return SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(high_thr) + 1));
		end
		return any_sample();
	endfunction

	// one measurement: a start, then ticks and shaped samples with a little
	// noise and the odd restart, until it ends or the step budget runs out
	task automatic run_measurement(int tick_pct, int tick_run_max, int step_cap);
		int steps;
		int r;
		int run;
		send_item(KIND_START, any_sample(), any_sample());
		steps = 0;
		while (meas_active && steps < step_cap) begin
			r = $urandom_range(99, 0);
			if (r < 2) begin
				send_item(KIND_SPARE, any_sample(), any_sample());
			end else if (r < 3) begin
				send_item(KIND_START, any_sample(), any_sample());
			end else if (r < 3 + tick_pct) begin
				run = $urandom_range(tick_run_max, 1);
				while (run > 0 && meas_active) begin
					send_item(KIND_TICK, any_sample(), any_sample());
					run--;
				end
			end else begin
				send_item(KIND_SAMPLE, shaped_sample(chan_a.phase),
					shaped_sample(chan_b.phase));
			end
			steps++;
		end
		// stray items between measurements, which the block ignores
		if (!meas_active)
			repeat ($urandom_range(2, 0))
				send_item(($urandom_range(1, 0) != 0) ? KIND_TICK : KIND_SAMPLE,
					any_sample(), any_sample());
	endtask

	// one register setting with its own sender and receiver behaviour
	task automatic run_phase(mix_t mix);
		int tick_pct;
		int tick_run_max;
		int step_cap;
		int meas_count;
		settle_block();
		tick_pct     = 25;
		tick_run_max = 3;
		step_cap     = 150;
		meas_count   = 4;
		case (mix)
			MIX_NOMINAL: begin
				set_register(REG_HIGH_THR, HIGH_THR_RST);
				set_register(REG_LOW_THR, LOW_THR_RST);
				set_register(REG_TIMEOUT, $urandom_range(3000, 200));
				gaps_on   = 1'b1;
				gap_max   = 4;
				sink_mode = SINK_RANDOM;
			end
			MIX_NO_EDGES: begin
				// no sample can be high or low: only timeouts end these
				set_register(REG_HIGH_THR, SAMPLE_MAX);
				set_register(REG_LOW_THR, 0);
				set_register(REG_TIMEOUT, $urandom_range(30, 1));
				gaps_on      = 1'b1;
				gap_max      = 8;
				sink_mode    = SINK_PATTERN;
				tick_pct     = 30;
				tick_run_max = 4;
			end
			MIX_ALWAYS_EDGES: begin
				set_register(REG_HIGH_THR, 0);
				set_register(REG_LOW_THR, SAMPLE_MAX);
				set_register(REG_TIMEOUT, $urandom_range(400, 50));
				gaps_on      = 1'b0;
				sink_mode    = SINK_ALWAYS;
				tick_pct     = 20;
				tick_run_max = 2;
			end
			MIX_RANDOM: begin
				set_register(REG_HIGH_THR, $urandom_range(SAMPLE_MAX, 0));
				set_register(REG_LOW_THR, $urandom_range(SAMPLE_MAX, 0));
				set_register(REG_TIMEOUT, $urandom_range(65535, 1));
				gaps_on      = 1'b1;
				gap_max      = 3;
				sink_mode    = SINK_RANDOM;
				tick_run_max = 5;
				step_cap     = 120;
			end
			MIX_INVERTED: begin
				// low above high: mid-range samples count as both
				set_register(REG_HIGH_THR, $urandom_range(300, 0));
				set_register(REG_LOW_THR, $urandom_range(SAMPLE_MAX, 600));
				set_register(REG_TIMEOUT, $urandom_range(1000, 100));
				gaps_on   = 1'b1;
				gap_max   = 6;
				sink_mode = SINK_PATTERN;
			end
			default: begin
				// long tick runs under the widest timeout, sent back to back
				set_register(REG_HIGH_THR, $urandom_range(700, 500));
				set_register(REG_LOW_THR, $urandom_range(400, 200));
				set_register(REG_TIMEOUT, 65535);
				gaps_on      = 1'b0;
				sink_mode    = SINK_ALWAYS;
				tick_pct     = 15;
				tick_run_max = 30;
				step_cap     = 40;
				meas_count   = 1;
			end
		endcase
		repeat (meas_count)
			run_measurement(tick_pct, tick_run_max, step_cap);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_register_reset();
		check_register(REG_HIGH_THR, HIGH_THR_RST);
		check_register(REG_LOW_THR, LOW_THR_RST);
		check_register(REG_TIMEOUT, TIMEOUT_RST);
	endtask

	// nothing is measuring yet, so none of these may produce a result
	task automatic test_idle_items();
		gaps_on   = 1'b0;
		sink_mode = SINK_ALWAYS;
		send_item(KIND_TICK, '0, '0);
		send_item(KIND_SAMPLE, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
		send_item(KIND_SPARE, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
		send_item(KIND_SAMPLE, '0, '0);
	endtask

	// a zero timeout ends each start at once with an empty result
	task automatic test_zero_timeout();
		settle_block();
		set_register(REG_TIMEOUT, 0);
		send_item(KIND_START, '0, '0);
		send_item(KIND_START, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
	endtask

	// a spare item is ignored mid-measurement; the single tick ends it
	task automatic test_single_tick_timeout();
		settle_block();
		set_register(REG_TIMEOUT, 1);
		gaps_on = 1'b1;
		gap_max = 3;
		send_item(KIND_START, '0, '0);
		send_item(KIND_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0);
		send_item(KIND_SPARE, '0, SAMPLE_W'(SAMPLE_MAX));
		send_item(KIND_TICK, '0, '0);
	endtask

	// a start while measuring throws away the beats already captured
	task automatic test_restart();
		settle_block();
		set_register(REG_TIMEOUT, 4);
		sink_mode = SINK_PATTERN;
		send_item(KIND_START, '0, '0);
		send_item(KIND_SAMPLE, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
		send_item(KIND_SAMPLE, '0, '0);
		send_item(KIND_SAMPLE, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
		send_item(KIND_TICK, '0, '0);
		send_item(KIND_START, '0, '0);
		repeat (4) send_item(KIND_TICK, '0, '0);
	endtask

	// compares are strict: the threshold value itself is neither high nor low
	task automatic test_threshold_edges();
		settle_block();
		set_register(REG_HIGH_THR, HIGH_THR_RST);
		set_register(REG_LOW_THR, LOW_THR_RST);
		set_register(REG_TIMEOUT, 3);
		gaps_on   = 1'b0;
		sink_mode = SINK_RANDOM;
		send_item(KIND_START, '0, '0);
		send_item(KIND_SAMPLE, SAMPLE_W'(HIGH_THR_RST), SAMPLE_W'(HIGH_THR_RST + 1));
		send_item(KIND_SAMPLE, SAMPLE_W'(LOW_THR_RST), SAMPLE_W'(LOW_THR_RST));
		send_item(KIND_SAMPLE, SAMPLE_W'(LOW_THR_RST - 1), SAMPLE_W'(LOW_THR_RST - 1));
		send_item(KIND_SAMPLE, SAMPLE_W'(HIGH_THR_RST + 1), SAMPLE_W'(SAMPLE_MAX));
		repeat (3) send_item(KIND_TICK, '0, '0);
	endtask

	// rotate through the settings until enough items and results have gone by
	task automatic test_random_measurements();
		int   first_items;
		int   first_results;
		mix_t mix;
		first_items   = effective_items;
		first_results = results_predicted;
		mix           = MIX_NOMINAL;
		while (((effective_items - first_items) < RANDOM_ITEMS ||
			(results_predicted - first_results) < RANDOM_RESULTS) &&
			(effective_items - first_items) < RANDOM_ITEM_CAP) begin
			run_phase(mix);
			mix = (mix == MIX_INVERTED) ? MIX_NOMINAL : mix_t'(mix + 1);
		end
	endtask

	task automatic test_long_intervals();
		run_phase(MIX_LONG);
	endtask

	// ------------------------------------------------------------------------
	// sequence: reset once, run the tests, drain, report
	// ------------------------------------------------------------------------
	initial begin
		clear_measurement();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_idle_items();
		test_zero_timeout();
		test_single_tick_timeout();
		test_restart();
		test_threshold_edges();
		test_random_measurements();
		test_long_intervals();

		settle_block();
		if (result_errors + reg_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
